// ===== hdl/dfaw_pkg.sv =====
// ----------------------------------------------------------------------------
// dfaw_pkg
// Request and result types, table entry layout and kind codes shared by the
// automaton word acceptor.
// ----------------------------------------------------------------------------
package dfaw_pkg;

    localparam int STATE_W  = 6;
    localparam int LETTER_W = 8;
    localparam int MASK_W   = 64;

    localparam logic [1:0] KIND_RULE   = 2'd0;
    localparam logic [1:0] KIND_LETTER = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    typedef struct packed {
        logic [1:0]          kind;
        logic [LETTER_W-1:0] letter;
        logic [STATE_W-1:0]  rule_from;
        logic [STATE_W-1:0]  rule_to;
    } t_in_item;

    typedef struct packed {
        logic                is_verdict;
        logic [STATE_W-1:0]  from_state;
        logic [LETTER_W-1:0] seen_letter;
        logic [STATE_W-1:0]  to_state;
        logic                step_ok;
        logic                accepted;
    } t_out_item;

    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] to_state;
    } t_entry;

endpackage

// ===== hdl/dfa_word_acceptor_top.sv =====
// ----------------------------------------------------------------------------
// dfa_word_acceptor_top
// Deterministic automaton over words fed one letter per request; the
// transition table lives in one synchronous memory indexed by state and letter.
// ----------------------------------------------------------------------------
// Letter request: table read into the registered read port, then state update with
//   the result pushed into the output stage; input stalls meanwhile. Rule and end-of-word need no table read.
// The letter rate is set by the read of the next state from the table memory.
// A two-entry output register and skid stage decouple the result side.
// Reset: synchronous; afterwards the table is swept to "no transition", one
//   entry a cycle, all 2**(clog2(NUM_STATES)+clog2(NUM_LETTERS)) entries (16384).
module dfa_word_acceptor_top
    import dfaw_pkg::*;
#(
    parameter int NUM_STATES  = 64,
    parameter int NUM_LETTERS = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [MASK_W-1:0]     i_cfg_data
);

    localparam int SW    = $clog2(NUM_STATES);
    localparam int LW    = $clog2(NUM_LETTERS);
    localparam int AW    = SW + LW;
    localparam int DEPTH = 1 << AW;

    localparam logic [STATE_W:0]  NS_LIM = (STATE_W+1)'(NUM_STATES);
    localparam logic [LETTER_W:0] NL_LIM = (LETTER_W+1)'(NUM_LETTERS);

    t_entry              r_mem [DEPTH];
    t_entry              r_rd;

    logic                r_clr;
    logic [AW-1:0]       r_clr_addr;
    logic                r_busy;
    logic                r_stopped;
    logic [STATE_W-1:0]  r_cur;
    logic [MASK_W-1:0]   r_final_mask;
    logic [LETTER_W-1:0] r_lk_letter;
    logic                r_lk_inrange;

    logic                r_out_valid;
    logic                r_skid_valid;
    t_out_item           r_out;
    t_out_item           r_skid;
    logic                n_out_valid;
    logic                n_skid_valid;
    t_out_item           n_out;
    t_out_item           n_skid;

    logic                w_in_acc;
    logic                w_is_rule;
    logic                w_is_letter;
    logic                w_is_end;
    logic                w_rule_ok;
    logic                w_letter_ok;
    logic                w_mem_we;
    logic [AW-1:0]       w_mem_waddr;
    t_entry              w_mem_wdata;
    logic                w_lookup;
    logic [AW-1:0]       w_rd_addr;
    logic                w_hit;
    logic                w_push;
    logic                w_pop;
    t_out_item           w_new;

    assign o_in_stall  = r_clr | r_busy | r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_in_acc = i_in_valid & ~o_in_stall;

    always_comb begin
        w_is_rule   = 1'b0;
        w_is_letter = 1'b0;
        w_is_end    = 1'b0;
        unique case (i_in_item.kind)
            KIND_RULE:   w_is_rule   = 1'b1;
            KIND_LETTER: w_is_letter = 1'b1;
            KIND_END:    w_is_end    = 1'b1;
            default: begin
            end
        endcase
    end

    assign w_rule_ok = ({1'b0, i_in_item.rule_from} < NS_LIM)
                     & ({1'b0, i_in_item.rule_to} < NS_LIM)
                     & ({1'b0, i_in_item.letter} < NL_LIM);
    assign w_letter_ok = ({1'b0, i_in_item.letter} < NL_LIM);

    assign w_mem_we    = r_clr | (w_in_acc & w_is_rule & w_rule_ok);
    assign w_mem_waddr = r_clr ? r_clr_addr
                               : {i_in_item.rule_from[SW-1:0], i_in_item.letter[LW-1:0]};
    assign w_mem_wdata = r_clr ? t_entry'('0)
                               : t_entry'{valid: 1'b1, to_state: i_in_item.rule_to};

    assign w_lookup  = w_in_acc & w_is_letter & ~r_stopped;
    assign w_rd_addr = {r_cur[SW-1:0], i_in_item.letter[LW-1:0]};

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_lookup) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    assign w_hit = r_rd.valid & r_lk_inrange;

    always_ff @(posedge i_clk) begin
        if (w_lookup) begin
            r_lk_letter  <= i_in_item.letter;
            r_lk_inrange <= w_letter_ok;
        end
    end

    always_comb begin
        w_new = '0;
        if (r_busy) begin
            w_new.from_state  = r_cur;
            w_new.seen_letter = r_lk_letter;
            w_new.to_state    = w_hit ? r_rd.to_state : '0;
            w_new.step_ok     = w_hit;
        end else begin
            w_new.is_verdict  = 1'b1;
            w_new.from_state  = r_cur;
            w_new.accepted    = ~r_stopped & r_final_mask[r_cur];
        end
    end

    assign w_push = r_busy | (w_in_acc & w_is_end);
    assign w_pop  = r_out_valid & ~i_out_stall;

    // output register with skid stage
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (w_push) begin
            if (~r_out_valid | (w_pop & ~r_skid_valid)) begin
                n_out_valid = 1'b1;
                n_out       = w_new;
            end else if (w_pop) begin
                n_out  = r_skid;
                n_skid = w_new;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = w_new;
            end
        end else if (w_pop) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr        <= 1'b1;
            r_clr_addr   <= '0;
            r_busy       <= 1'b0;
            r_stopped    <= 1'b0;
            r_cur        <= '0;
            r_final_mask <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
            if (i_cfg_valid & o_cfg_ready) begin
                r_final_mask <= i_cfg_data;
            end
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == '1) begin
                    r_clr <= 1'b0;
                end
            end
            r_busy <= w_lookup;
            // advance on hit, stop on miss
            if (r_busy) begin
                if (w_hit) begin
                    r_cur <= r_rd.to_state;
                end else begin
                    r_stopped <= 1'b1;
                end
            end
            if (w_in_acc & w_is_end) begin
                r_cur     <= '0;
                r_stopped <= 1'b0;
            end
        end
    end

    a_lookup_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> !r_busy)
        else $error("lookup held for more than one cycle");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a result ahead of the output register");

    a_miss_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !w_hit) |=> r_stopped)
        else $error("missing transition did not stop the word");

    a_quiet_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> (!r_busy && !r_out_valid))
        else $error("activity during table clear");

endmodule

// ===== bench/dfaw_trace_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dfaw_trace_checker
// Watches the request, result and mask channels of the word acceptor, runs
// its own copy of the automaton on every accepted request, and compares
// each accepted result field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module dfaw_trace_checker
    import dfaw_pkg::*;
#(
    parameter int NUM_STATES  = 64,
    parameter int NUM_LETTERS = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  t_in_item          i_in_item,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  t_out_item         i_out_item,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [MASK_W-1:0] i_cfg_data,
    output int                o_pending,
    output int                o_errors
);

    localparam int ARC_DEPTH = NUM_STATES * NUM_LETTERS;

    t_entry             arcs [ARC_DEPTH];
    logic [MASK_W-1:0]  accept_mask;
    logic [STATE_W-1:0] cur_state;
    logic               halted;
    t_out_item          trace_q [$];
    int                 errors = 0;

    task automatic apply_request(input t_in_item req);
        t_out_item res;
        int        idx;
        bit        emit;
        res  = '0;
        emit = 1'b0;
        case (req.kind)
            KIND_RULE: begin
                if (req.rule_from < NUM_STATES && req.rule_to < NUM_STATES &&
                    req.letter < NUM_LETTERS) begin
                    idx = int'(req.rule_from) * NUM_LETTERS + int'(req.letter);
                    arcs[idx].valid    = 1'b1;
                    arcs[idx].to_state = req.rule_to;
                end
            end
            KIND_LETTER: begin
                if (!halted) begin
                    emit             = 1'b1;
                    res.from_state   = cur_state;
                    res.seen_letter  = req.letter;
                    idx = int'(cur_state) * NUM_LETTERS + int'(req.letter);
                    if (req.letter < NUM_LETTERS && cur_state < NUM_STATES &&
                        arcs[idx].valid) begin
                        cur_state    = arcs[idx].to_state;
                        res.to_state = cur_state;
                        res.step_ok  = 1'b1;
                    end else begin
                        halted = 1'b1;
                    end
                end
            end
            KIND_END: begin
                emit           = 1'b1;
                res.is_verdict = 1'b1;
                res.from_state = cur_state;
                res.accepted   = !halted && accept_mask[cur_state];
                cur_state      = '0;
                halted         = 1'b0;
            end
            default: ;
        endcase
        if (emit) trace_q.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            foreach (arcs[i]) arcs[i] = '0;
            accept_mask = '0;
            cur_state   = '0;
            halted      = 1'b0;
            trace_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) accept_mask = i_cfg_data;
            if (i_in_valid && !i_in_stall) apply_request(i_in_item);
            if (i_out_valid && !i_out_stall) begin
                if (trace_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, i_out_item);
                end else begin
                    want = trace_q.pop_front();
                    check_field("is_verdict", 8'(want.is_verdict), 8'(i_out_item.is_verdict));
                    check_field("from_state", 8'(want.from_state), 8'(i_out_item.from_state));
                    check_field("seen_letter", want.seen_letter, i_out_item.seen_letter);
                    check_field("to_state", 8'(want.to_state), 8'(i_out_item.to_state));
                    check_field("step_ok", 8'(want.step_ok), 8'(i_out_item.step_ok));
                    check_field("accepted", 8'(want.accepted), 8'(i_out_item.accepted));
                end
            end
        end
        o_pending <= trace_q.size();
        o_errors  <= errors;
    end

endmodule

// ===== bench/dfa_word_acceptor_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dfa_word_acceptor_top_tb
// Drives rule, letter and end-of-word requests into the word acceptor with
// random gaps and result-side stalls, changes the accepting-state mask
// between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module dfa_word_acceptor_top_tb;
    import dfaw_pkg::*;

    localparam logic [1:0] KIND_NONE   = 2'd3;
    localparam int         SETTLE      = 16;
    localparam int         CYCLE_LIMIT = 1_000_000;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    t_in_item          in_item   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_out_item         out_item;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [MASK_W-1:0] cfg_data  = '0;

    int pending;
    int errors;
    int cycles     = 0;
    int idle_pct   = 0;
    int stall_pct  = 0;
    int long_hold  = 0;
    int sent_count = 0;

    logic [STATE_W-1:0]  state_pool  [8];
    logic [LETTER_W-1:0] letter_pool [6];
    int                  pool_states;
    int                  pool_letters;

    always #5 clk = ~clk;

    dfa_word_acceptor_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    dfaw_trace_checker trace_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // hold the result side: long hold-off on request, else random stalls
    initial begin
        int n;
        forever begin
            @(posedge clk);
            if (long_hold != 0) begin
                n         = long_hold;
                long_hold = 0;
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
                n = ($urandom_range(19) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_req(input logic [1:0] kind, input logic [LETTER_W-1:0] letter,
                            input logic [STATE_W-1:0] from, input logic [STATE_W-1:0] to);
        t_in_item req;
        int       gap;
        req.kind      = kind;
        req.letter    = letter;
        req.rule_from = from;
        req.rule_to   = to;
        gap = 0;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
            gap = ($urandom_range(19) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (kind != KIND_NONE) sent_count++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_mask(input logic [MASK_W-1:0] mask);
        cfg_valid <= 1'b1;
        cfg_data  <= mask;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic build_automaton();
        pool_states    = $urandom_range(8, 2);
        pool_letters   = $urandom_range(6, 1);
        state_pool[0]  = '0;
        for (int i = 1; i < pool_states; i++) state_pool[i] = STATE_W'($urandom);
        for (int i = 0; i < pool_letters; i++) letter_pool[i] = LETTER_W'($urandom);
        for (int s = 0; s < pool_states; s++)
            for (int l = 0; l < pool_letters; l++)
                if ($urandom_range(99) < 85)
                    send_req(KIND_RULE, letter_pool[l], state_pool[s],
                             state_pool[$urandom_range(pool_states - 1)]);
    endtask

    task automatic run_phase(input int n_reqs);
        int goal;
        int len;
        int pick;
        goal = sent_count + n_reqs;
        build_automaton();
        while (sent_count < goal) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
                build_automaton();
            end else if (pick < 13) begin
                send_req(KIND_RULE, LETTER_W'($urandom), STATE_W'($urandom), STATE_W'($urandom));
            end else if (pick < 18) begin
                send_req(KIND_NONE, LETTER_W'($urandom), STATE_W'($urandom), STATE_W'($urandom));
            end else begin
                len = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 0);
                repeat (len) begin
                    if ($urandom_range(29) == 0)
                        send_req(KIND_NONE, LETTER_W'($urandom), STATE_W'($urandom),
                                 STATE_W'($urandom));
                    if ($urandom_range(9) == 0)
                        send_req(KIND_LETTER, LETTER_W'($urandom), STATE_W'($urandom),
                                 STATE_W'($urandom));
                    else
                        send_req(KIND_LETTER, letter_pool[$urandom_range(pool_letters - 1)],
                                 STATE_W'($urandom), STATE_W'($urandom));
                end
                send_req(KIND_END, LETTER_W'($urandom), STATE_W'($urandom), STATE_W'($urandom));
            end
        end
    endtask

    initial begin
        logic [MASK_W-1:0] mask;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        write_mask({1'b1, {(MASK_W-2){1'b0}}, 1'b1});
        send_req(KIND_END,    8'h00, '0, '0);
        send_req(KIND_LETTER, 8'h00, '1, '1);
        send_req(KIND_LETTER, 8'hFF, '0, '0);
        send_req(KIND_END,    8'hFF, '1, '1);
        send_req(KIND_RULE,   8'hFF, 6'd0, 6'd63);
        send_req(KIND_RULE,   8'h00, 6'd63, 6'd63);
        send_req(KIND_RULE,   8'hFF, 6'd63, 6'd0);
        send_req(KIND_NONE,   8'hFF, '1, '1);
        send_req(KIND_LETTER, 8'hFF, '0, '0);
        send_req(KIND_LETTER, 8'h00, '0, '0);
        send_req(KIND_END,    8'h00, '0, '0);
        send_req(KIND_RULE,   8'hFF, 6'd0, 6'd1);
        send_req(KIND_LETTER, 8'hFF, '0, '0);
        send_req(KIND_LETTER, 8'h55, '0, '0);
        send_req(KIND_END,    8'h00, '0, '0);
        send_req(KIND_RULE,   8'hAA, 6'd1, 6'd42);
        send_req(KIND_LETTER, 8'hFF, '0, '0);
        send_req(KIND_LETTER, 8'hAA, '0, '0);
        send_req(KIND_END,    8'h00, '0, '0);
        send_req(KIND_LETTER, 8'hFF, '0, '0);
        send_req(KIND_END,    8'h00, '0, '0);
        wait_idle();
        write_mask('1);
        send_req(KIND_LETTER, 8'hFF, '0, '0);
        send_req(KIND_END,    8'h00, '0, '0);
        send_req(KIND_END,    8'h00, '0, '0);
        wait_idle();
        write_mask('0);
        send_req(KIND_END,    8'h00, '0, '0);
        wait_idle();

        for (int p = 0; p < 5; p++) begin
            case (p)
                0:       mask = '1;
                2:       mask = '0;
                3:       mask = {(MASK_W/2){2'b10}};
                default: mask = {$urandom, $urandom};
            endcase
            idle_pct  = (p == 0) ? 0 : $urandom_range(50, 10);
            stall_pct = (p == 0) ? 0 : $urandom_range(50, 10);
            write_mask(mask);
            if (p == 2) long_hold = 400;
            run_phase(380);
            wait_idle();
        end

        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/dfaw_pkg.sv
hdl/dfa_word_acceptor_top.sv
bench/dfaw_trace_checker.sv
bench/dfa_word_acceptor_top_tb.sv
